FILE: design/kmer_presence_bitmap_core_assert.svh
// Assertion macros for the k-mer presence bitmap core.
// No dependencies; included by kpb_back, which carries the concurrent checks.
`ifndef KMER_PRESENCE_BITMAP_CORE_ASSERT_SVH
`define KMER_PRESENCE_BITMAP_CORE_ASSERT_SVH

// A condition that holds at every clock edge outside reset.
`define KPB_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A consequence that holds in the same cycle as its trigger.
`define KPB_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// A consequence that holds in the cycle after its trigger.
`define KPB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/kpb_pkg.sv
// Shared types, field widths and character codes for the k-mer presence bitmap core.
// No dependencies; imported by every module of the block.
package kpb_pkg;

   // Field widths of the ports.
   localparam int KMER_LEN_W = 4;
   localparam int TAIL_W     = 32;
   localparam int CMD_W      = 2;
   localparam int CHAR_W     = 8;
   localparam int LEFT_W     = 32;
   localparam int DISTINCT_W = 17;
   localparam int MISSING_W  = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;

   // Default longest fragment length.
   localparam int MAX_K_DEFAULT = 8;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_KMER_LEN   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TAIL_LIMIT = 1'd1;

   // Input commands.
   typedef enum logic [CMD_W-1:0] {
      CMD_BASE  = 2'd0,
      CMD_CLEAR = 2'd1,
      CMD_SCAN  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   // Operations passed from the front end to the bitmap engine.
   typedef enum logic [1:0] {
      OP_STATUS = 2'd0,
      OP_SET    = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_SCAN   = 2'd3
   } op_type;

   // ASCII codes of the accepted bases.
   localparam logic [CHAR_W-1:0] CHAR_A_UP = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_A_LO = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_C_UP = 8'h43;
   localparam logic [CHAR_W-1:0] CHAR_C_LO = 8'h63;
   localparam logic [CHAR_W-1:0] CHAR_G_UP = 8'h47;
   localparam logic [CHAR_W-1:0] CHAR_G_LO = 8'h67;
   localparam logic [CHAR_W-1:0] CHAR_T_UP = 8'h54;
   localparam logic [CHAR_W-1:0] CHAR_T_LO = 8'h74;

   // Decoded base: a 2-bit value and a flag for a valid letter.
   typedef struct packed {
      logic       valid;
      logic [1:0] value;
   } base_type;

   // Maps an ASCII character to its 2-bit base code.
   function automatic base_type base_decode(input logic [CHAR_W-1:0] ch);
      base_type res;
      res.valid = 1'b1;
      unique case (ch) inside
         CHAR_A_UP, CHAR_A_LO: res.value = 2'd0;
         CHAR_C_UP, CHAR_C_LO: res.value = 2'd1;
         CHAR_G_UP, CHAR_G_LO: res.value = 2'd2;
         CHAR_T_UP, CHAR_T_LO: res.value = 2'd3;
         default: begin
            res.valid = 1'b0;
            res.value = 2'd0;
         end
      endcase
      return res;
   endfunction

endpackage

FILE: design/kmer_presence_bitmap_core.sv
// Bases: the engine takes no new base until the read-modify-write of the presence memory ends.
// Scan reads one 32-bit memory row a cycle; clear sweeps 2^(2*MAX_K-5) rows, one a cycle.
// Reset: synchronous, active high; afterwards the same sweep clears the memory while
// req_ready stays low. Configuration writes are taken throughout.
module kmer_presence_bitmap_core #(
   parameter int MAX_K = kpb_pkg::MAX_K_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [kpb_pkg::CMD_W-1:0]       req_cmd,
   input  logic [kpb_pkg::CHAR_W-1:0]      req_base_char,
   input  logic                            req_seq_start,
   input  logic [kpb_pkg::LEFT_W-1:0]      req_bases_left,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_full_res,
   output logic [kpb_pkg::DISTINCT_W-1:0]  rsp_distinct_count,
   output logic [kpb_pkg::MISSING_W-1:0]   rsp_missing_code,
   output logic                            rsp_missing_found,
   input  logic                            csr_wr_en,
   input  logic [kpb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [kpb_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import kpb_pkg::*;

   localparam int CODE_W  = 2 * MAX_K;
   localparam int K_W     = $clog2(MAX_K + 1);
   localparam int OP_W    = $bits(op_type);
   localparam int ENTRY_W = OP_W + CODE_W;

   logic               init_busy;
   logic               q_full;
   logic               push_valid;
   op_type             push_op;
   logic [CODE_W-1:0]  push_code;
   logic [K_W-1:0]     k_eff;
   logic               q_pop;
   logic               q_valid;
   logic [ENTRY_W-1:0] q_data;
   op_type             q_op;
   logic [CODE_W-1:0]  q_code;

   // Front end: configuration, window and classification.
   kpb_front #(
      .MAX_K(MAX_K)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cmd       (req_cmd),
      .req_base_char (req_base_char),
      .req_seq_start (req_seq_start),
      .req_bases_left(req_bases_left),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .init_busy     (init_busy),
      .q_full        (q_full),
      .push_valid    (push_valid),
      .push_op       (push_op),
      .push_code     (push_code),
      .k_eff         (k_eff)
   );

   // Operation queue between the two sides.
   kpb_queue #(
      .DATA_W(ENTRY_W)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push_valid),
      .push_data({push_op, push_code}),
      .full     (q_full),
      .pop      (q_pop),
      .pop_valid(q_valid),
      .pop_data (q_data)
   );

   assign q_op   = op_type'(q_data[ENTRY_W-1:CODE_W]);
   assign q_code = q_data[CODE_W-1:0];

   // Bitmap engine and result register.
   kpb_back #(
      .MAX_K(MAX_K)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .k_eff             (k_eff),
      .q_valid           (q_valid),
      .q_op              (q_op),
      .q_code            (q_code),
      .q_pop             (q_pop),
      .init_busy         (init_busy),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_full_res      (rsp_full_res),
      .rsp_distinct_count(rsp_distinct_count),
      .rsp_missing_code  (rsp_missing_code),
      .rsp_missing_found (rsp_missing_found)
   );

endmodule

FILE: design/kpb_front.sv
// Front end of the k-mer presence bitmap core: configuration registers, rolling window
// and command classification. Depends on kpb_pkg.
module kpb_front #(
   parameter int MAX_K = kpb_pkg::MAX_K_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [kpb_pkg::CMD_W-1:0]       req_cmd,
   input  logic [kpb_pkg::CHAR_W-1:0]      req_base_char,
   input  logic                            req_seq_start,
   input  logic [kpb_pkg::LEFT_W-1:0]      req_bases_left,
   input  logic                            csr_wr_en,
   input  logic [kpb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [kpb_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                            init_busy,
   input  logic                            q_full,
   output logic                            push_valid,
   output kpb_pkg::op_type                 push_op,
   output logic [2*MAX_K-1:0]              push_code,
   output logic [$clog2(MAX_K+1)-1:0]      k_eff
);
   import kpb_pkg::*;

   localparam int CODE_W = 2 * MAX_K;
   localparam int K_W    = $clog2(MAX_K + 1);

   logic [KMER_LEN_W-1:0] kmer_len_ff;
   logic [TAIL_W-1:0]     tail_limit_ff;
   logic [CODE_W-1:0]     window_ff;
   logic [CODE_W-1:0]     window_in;
   logic [K_W-1:0]        run_ff;
   logic [K_W-1:0]        run_in;
   logic [K_W-1:0]        run_base;
   logic [K_W-1:0]        run_inc;
   logic [CODE_W-1:0]     window_shift;
   logic [CODE_W-1:0]     window_mask;
   logic [K_W:0]          place_amt;
   base_type              decoded;
   cmd_type               cmd;
   logic                  tail_skip;
   logic                  base_ok;
   logic                  accept;

   // Effective fragment length: zero acts as one, large values clamp to the maximum.
   always_comb begin
      if (kmer_len_ff == '0) begin
         k_eff = K_W'(1);
      end else if ({1'b0, kmer_len_ff} > (KMER_LEN_W+1)'(MAX_K)) begin
         k_eff = K_W'(MAX_K);
      end else begin
         k_eff = K_W'(kmer_len_ff);
      end
   end

   // Classify the beat and work out the next window.
   assign cmd         = cmd_type'(req_cmd);
   assign decoded     = base_decode(req_base_char);
   assign tail_skip   = (tail_limit_ff != '0) && (req_bases_left > tail_limit_ff);
   assign base_ok     = decoded.valid && !tail_skip;
   assign run_base    = req_seq_start ? '0 : run_ff;
   assign run_inc     = (run_base < k_eff) ? run_base + 1'b1 : run_base;
   assign place_amt   = {k_eff - 1'b1, 1'b0};
   assign window_mask = ~({CODE_W{1'b1}} << {k_eff, 1'b0});
   assign window_shift = ((window_ff >> 2) | (CODE_W'(decoded.value) << place_amt))
                         & window_mask;

   assign req_ready  = !q_full && !init_busy;
   assign accept     = req_valid && req_ready;
   assign push_valid = accept;
   assign push_code  = window_shift;

   // Operation for the engine and next window state.
   always_comb begin
      window_in = window_ff;
      run_in    = run_ff;
      push_op   = OP_STATUS;
      unique case (cmd)
         CMD_BASE: begin
            if (base_ok) begin
               window_in = window_shift;
               run_in    = run_inc;
               if (run_inc >= k_eff) begin
                  push_op = OP_SET;
               end
            end else begin
               run_in = '0;
            end
         end
         CMD_CLEAR: begin
            window_in = '0;
            run_in    = '0;
            push_op   = OP_CLEAR;
         end
         CMD_SCAN: begin
            push_op = OP_SCAN;
         end
         CMD_NONE: begin
            push_op = OP_STATUS;
         end
      endcase
   end

   // Registers: configuration and window state.
   always_ff @(posedge clock) begin
      if (reset) begin
         kmer_len_ff   <= KMER_LEN_W'(1);
         tail_limit_ff <= '0;
         window_ff     <= '0;
         run_ff        <= '0;
      end else begin
         if (accept) begin
            window_ff <= window_in;
            run_ff    <= run_in;
         end
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_KMER_LEN: begin
                  kmer_len_ff <= csr_wdata[KMER_LEN_W-1:0];
                  window_ff   <= '0;
                  run_ff      <= '0;
               end
               CSR_TAIL_LIMIT: begin
                  tail_limit_ff <= csr_wdata[TAIL_W-1:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

endmodule

FILE: design/kpb_queue.sv
// Two-entry queue between the front end and the bitmap engine.
// Depends on kpb_pkg only through the house import convention.
module kpb_queue #(
   parameter int DATA_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic              pop_valid,
   output logic [DATA_W-1:0] pop_data
);
   import kpb_pkg::*;

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);

   logic [DATA_W-1:0] entries_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [PTR_W:0]    count_ff;
   logic [PTR_W:0]    count_in;

   assign full      = (count_ff == (PTR_W+1)'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = entries_ff[rd_ptr_ff];

   // Occupancy follows the push and pop beats.
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   // Pointers and occupancy.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: design/kpb_back.sv
// Bitmap engine of the k-mer presence bitmap core: presence memory, distinct count,
// clearing sweep, missing-code scan and result register. Depends on kpb_pkg.
`include "kmer_presence_bitmap_core_assert.svh"

module kpb_back #(
   parameter int MAX_K = kpb_pkg::MAX_K_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [$clog2(MAX_K+1)-1:0]       k_eff,
   input  logic                             q_valid,
   input  kpb_pkg::op_type                  q_op,
   input  logic [2*MAX_K-1:0]               q_code,
   output logic                             q_pop,
   output logic                             init_busy,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_full_res,
   output logic [kpb_pkg::DISTINCT_W-1:0]   rsp_distinct_count,
   output logic [kpb_pkg::MISSING_W-1:0]    rsp_missing_code,
   output logic                             rsp_missing_found
);
   import kpb_pkg::*;

   localparam int CODE_W   = 2 * MAX_K;
   localparam int CNT_W    = CODE_W + 1;
   localparam int WORD_LOG = (CODE_W > 5) ? 5 : CODE_W - 1;
   localparam int WORD_W   = 1 << WORD_LOG;
   localparam int ROW_W    = CODE_W - WORD_LOG;
   localparam int ROWS     = 1 << ROW_W;
   localparam logic [CNT_W-1:0] CODE_SPACE = {1'b1, {CODE_W{1'b0}}};

   typedef enum logic [1:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_SET_CHK,
      ST_SCAN_CHK
   } state_type;

   state_type          state_ff;
   logic [ROW_W-1:0]   sweep_addr_ff;
   logic               sweep_cmd_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic [CNT_W-1:0]   cursor_ff;
   logic [CODE_W-1:0]  cur_code_ff;
   logic [ROW_W-1:0]   scan_row_ff;
   logic [WORD_LOG-1:0] scan_off_ff;
   logic               rsp_valid_ff;
   logic               rsp_full_ff;
   logic [CNT_W-1:0]   rsp_count_ff;
   logic [CODE_W-1:0]  rsp_code_ff;
   logic               rsp_found_ff;

   logic [WORD_W-1:0]  seen_mem_ff [ROWS];
   logic [WORD_W-1:0]  rd_data_ff;
   logic               mem_re;
   logic [ROW_W-1:0]   mem_raddr;
   logic               mem_we;
   logic [ROW_W-1:0]   mem_waddr;
   logic [WORD_W-1:0]  mem_wdata;

   logic [CNT_W-1:0]   space;
   logic               slot_free;
   logic               set_hit;
   logic [WORD_W-1:0]  limit_mask;
   logic [WORD_W-1:0]  scan_word;
   logic               scan_found;
   logic [WORD_LOG-1:0] scan_idx;
   logic [CODE_W-1:0]  scan_code;
   logic [ROW_W:0]     row_next;
   logic [CNT_W-1:0]   row_next_start;
   logic               scan_done;
   logic               cursor_out;

   // Code space of the current fragment length and result-slot status.
   assign space      = CNT_W'(1) << {k_eff, 1'b0};
   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign q_pop      = (state_ff == ST_IDLE) && q_valid && slot_free;
   assign init_busy  = (state_ff == ST_SWEEP) && !sweep_cmd_ff;
   assign cursor_out = (cursor_ff >= space);

   // Presence test of the word read for a base.
   assign set_hit  = rd_data_ff[cur_code_ff[WORD_LOG-1:0]];
   assign count_in = ((state_ff == ST_SET_CHK) && !set_hit) ? count_ff + 1'b1 : count_ff;

   // Scan: candidate bits are absent codes at or above the cursor and inside the space.
   always_comb begin
      if (space >= CNT_W'(WORD_W)) begin
         limit_mask = '1;
      end else begin
         limit_mask = (WORD_W'(1) << space[WORD_LOG-1:0]) - 1'b1;
      end
   end
   assign scan_word = ~rd_data_ff & ({WORD_W{1'b1}} << scan_off_ff) & limit_mask;

   // Lowest candidate bit of the word.
   always_comb begin
      scan_found = 1'b0;
      scan_idx   = '0;
      for (int j = WORD_W - 1; j >= 0; j--) begin
         if (scan_word[j]) begin
            scan_found = 1'b1;
            scan_idx   = WORD_LOG'(j);
         end
      end
   end
   assign scan_code      = {scan_row_ff, scan_idx};
   assign row_next       = {1'b0, scan_row_ff} + 1'b1;
   assign row_next_start = {row_next, {WORD_LOG{1'b0}}};
   assign scan_done      = (row_next_start >= space);

   // Memory port control.
   always_comb begin
      mem_re    = 1'b0;
      mem_raddr = '0;
      mem_we    = 1'b0;
      mem_waddr = '0;
      mem_wdata = '0;
      unique case (state_ff)
         ST_SWEEP: begin
            mem_we    = 1'b1;
            mem_waddr = sweep_addr_ff;
         end
         ST_IDLE: begin
            if (q_pop && (q_op == OP_SET)) begin
               mem_re    = 1'b1;
               mem_raddr = q_code[CODE_W-1:WORD_LOG];
            end else if (q_pop && (q_op == OP_SCAN) && !cursor_out) begin
               mem_re    = 1'b1;
               mem_raddr = cursor_ff[CODE_W-1:WORD_LOG];
            end
         end
         ST_SET_CHK: begin
            mem_we    = !set_hit;
            mem_waddr = cur_code_ff[CODE_W-1:WORD_LOG];
            mem_wdata = rd_data_ff | (WORD_W'(1) << cur_code_ff[WORD_LOG-1:0]);
         end
         ST_SCAN_CHK: begin
            mem_re    = !scan_found && !scan_done;
            mem_raddr = row_next[ROW_W-1:0];
         end
      endcase
   end

   // Presence memory with registered read data.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         seen_mem_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= seen_mem_ff[mem_raddr];
      end
   end

   // Engine state, counters and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         sweep_addr_ff <= '0;
         sweep_cmd_ff  <= 1'b0;
         count_ff      <= '0;
         cursor_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         count_ff <= count_in;
         unique case (state_ff)
            ST_SWEEP: begin
               sweep_addr_ff <= sweep_addr_ff + 1'b1;
               if (sweep_addr_ff == '1) begin
                  state_ff <= ST_IDLE;
                  if (sweep_cmd_ff) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_full_ff  <= (count_ff == space);
                     rsp_count_ff <= count_ff;
                     rsp_code_ff  <= '0;
                     rsp_found_ff <= 1'b0;
                  end
                  sweep_cmd_ff <= 1'b0;
               end
            end
            ST_IDLE: begin
               if (q_pop) begin
                  case (q_op)
                     OP_SET: begin
                        cur_code_ff <= q_code;
                        state_ff    <= ST_SET_CHK;
                     end
                     OP_CLEAR: begin
                        count_ff     <= '0;
                        cursor_ff    <= '0;
                        sweep_cmd_ff <= 1'b1;
                        state_ff     <= ST_SWEEP;
                     end
                     OP_SCAN: begin
                        if (cursor_out) begin
                           rsp_valid_ff <= 1'b1;
                           rsp_full_ff  <= (count_ff == space);
                           rsp_count_ff <= count_ff;
                           rsp_code_ff  <= '0;
                           rsp_found_ff <= 1'b0;
                        end else begin
                           scan_row_ff <= cursor_ff[CODE_W-1:WORD_LOG];
                           scan_off_ff <= cursor_ff[WORD_LOG-1:0];
                           state_ff    <= ST_SCAN_CHK;
                        end
                     end
                     default: begin
                        rsp_valid_ff <= 1'b1;
                        rsp_full_ff  <= (count_ff == space);
                        rsp_count_ff <= count_ff;
                        rsp_code_ff  <= '0;
                        rsp_found_ff <= 1'b0;
                     end
                  endcase
               end
            end
            ST_SET_CHK: begin
               rsp_valid_ff <= 1'b1;
               rsp_full_ff  <= (count_in == space);
               rsp_count_ff <= count_in;
               rsp_code_ff  <= '0;
               rsp_found_ff <= 1'b0;
               state_ff     <= ST_IDLE;
            end
            ST_SCAN_CHK: begin
               if (scan_found) begin
                  cursor_ff    <= CNT_W'(scan_code) + 1'b1;
                  rsp_valid_ff <= 1'b1;
                  rsp_full_ff  <= (count_ff == space);
                  rsp_count_ff <= count_ff;
                  rsp_code_ff  <= scan_code;
                  rsp_found_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end else if (scan_done) begin
                  cursor_ff    <= space;
                  rsp_valid_ff <= 1'b1;
                  rsp_full_ff  <= (count_ff == space);
                  rsp_count_ff <= count_ff;
                  rsp_code_ff  <= '0;
                  rsp_found_ff <= 1'b0;
                  state_ff     <= ST_IDLE;
               end else begin
                  scan_row_ff <= row_next[ROW_W-1:0];
                  scan_off_ff <= '0;
               end
            end
         endcase
      end
   end

   // Result ports.
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_full_res       = rsp_full_ff;
   assign rsp_distinct_count = DISTINCT_W'(rsp_count_ff);
   assign rsp_missing_code   = MISSING_W'(rsp_code_ff);
   assign rsp_missing_found  = rsp_found_ff;

   // The distinct count and the scan cursor never pass the full code space.
   `KPB_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CODE_SPACE, "distinct count beyond code space")
   `KPB_ASSERT_ALWAYS(a_cursor_bound, clock, reset, cursor_ff <= CODE_SPACE, "scan cursor beyond code space")
   // While an operation is under way its result slot must be empty.
   `KPB_ASSERT_IMPLY(a_slot_empty, clock, reset, (state_ff == ST_SET_CHK) || (state_ff == ST_SCAN_CHK), !rsp_valid_ff, "result slot busy during an operation")
   // A first sighting of a code raises the count by exactly one.
   `KPB_ASSERT_NEXT(a_set_counts, clock, reset, (state_ff == ST_SET_CHK) && !set_hit, count_ff == $past(count_ff) + 1'b1, "new code not counted")
   // A reported missing code lies inside the current code space.
   `KPB_ASSERT_IMPLY(a_found_in_space, clock, reset, rsp_valid_ff && rsp_found_ff, CNT_W'(rsp_code_ff) < space, "missing code outside code space")

endmodule
